### rtl/core/mrrf_pkg.sv
// types, codes and crc step shared by the modbus ram read framer
package mrrf_pkg;

  // crc-16/modbus constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // reset values of the configuration registers
  localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'h68;
  localparam logic [6:0] FUNCTION_CODE_RESET  = 7'h44;

  // reply bytes beyond the payload: device, function, count, crc low, crc high
  localparam int unsigned REPLY_OVERHEAD = 5;

  // request run length and number of bytes staged in the shift line
  localparam int unsigned REQ_LEN   = 7;
  localparam int unsigned REQ_STAGE = 5;

  // configuration register indexes
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_FUNCTION_CODE  = 2'd1;

  // unused mode code, ignored by the block
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_RX      = 2'd1,
    MODE_TIMEOUT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_REQUEST = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_STATUS  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_EXCEPTION = 3'd2,
    ST_HEADER    = 3'd3,
    ST_CRC       = 3'd4
  } status_t;

  typedef enum logic {
    PH_IDLE    = 1'b0,
    PH_RECEIVE = 1'b1
  } phase_t;

  // one result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    status_t    status;
  } out_word_t;

  // one byte of crc-16/modbus, eight reflected bit steps
  function automatic logic [15:0] crc16_step(input logic [15:0] crc_in,
                                             input logic [7:0]  byte_in);
    logic [15:0] c;
    c = crc_in ^ {8'h00, byte_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/modbus_ram_read_framer.sv
// modbus ram read framer: request builder, reply checker and output word queue
//
//  channel | direction | handshake          | contents
//  s_*     | in        | s_tvalid/s_tready  | command word: mode, address, count, rx byte
//  m_*     | out       | m_tvalid/m_tready  | request byte, payload byte or final status
//  cfg_*   | in        | cfg_valid/cfg_ready| register index and write data
//
// Each command word is decoded in its accept cycle; its results land in an
// output queue of up to seven words that drains one word per cycle while
// m_tready is high. A start gives seven words, so it holds the input until
// they have drained; received bytes give at most two words, timeouts one.
// The next word is taken while the last queued word is being taken.
// The request crc is built one byte per sent word from the queue head.
// Reset (rst, synchronous) empties the queue and returns to idle.
module modbus_ram_read_framer
  import mrrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // command words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // read_addr[15:0], byte_count[23:16], rx_byte[31:24]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // data_byte[7:0], status[10:8], zero[15:11]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // configuration
  logic [7:0] device_address;
  logic [6:0] function_code;

  // reply tracking state
  phase_t      phase, phase_next;
  logic [8:0]  received_count, received_count_next;
  logic [7:0]  expected_payload, expected_payload_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] held_bytes, held_bytes_next;
  logic [7:0]  second_byte, second_byte_next;
  logic        header_bad, header_bad_next;

  // output queue
  out_word_t   words [REQ_STAGE];
  out_word_t   ld_words [REQ_STAGE];
  logic [2:0]  out_cnt;
  logic        out_req;
  logic [15:0] tx_crc;
  logic        ld_en;
  logic [2:0]  ld_cnt;
  logic        ld_req;
  out_word_t   head;

  logic accept, pop;

  // input field views
  logic [15:0] in_addr;
  logic [7:0]  in_count, in_rx;
  assign in_addr  = s_tdata[15:0];
  assign in_count = s_tdata[23:16];
  assign in_rx    = s_tdata[31:24];

  // handshakes
  assign cfg_ready = 1'b1;
  assign s_tready  = (out_cnt == 3'd0) || ((out_cnt == 3'd1) && m_tready);
  assign accept    = s_tvalid && s_tready;
  assign m_tvalid  = (out_cnt != 3'd0);
  assign pop       = m_tvalid && m_tready;

  // queue head, the two crc bytes of a request come from the tx crc
  always_comb begin
    head = words[0];
    if (out_req && (out_cnt <= 3'd2)) begin
      head.kind   = KIND_REQUEST;
      head.data   = (out_cnt == 3'd2) ? tx_crc[7:0] : tx_crc[15:8];
      head.last   = (out_cnt == 3'd1);
      head.status = ST_OK;
    end
  end

  assign m_tdata = {5'd0, head.status, head.data};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

  // decode of one command word
  always_comb begin
    logic [9:0]  n_total;
    logic [9:0]  i_plus2;
    logic [9:0]  i_plus1;
    logic        has_payload;
    logic        final_byte;
    status_t     st;
    out_word_t   pay_w, st_w;

    phase_next            = phase;
    received_count_next   = received_count;
    expected_payload_next = expected_payload;
    running_crc_next      = running_crc;
    held_bytes_next       = held_bytes;
    second_byte_next      = second_byte;
    header_bad_next       = header_bad;
    ld_en  = 1'b0;
    ld_cnt = 3'd0;
    ld_req = 1'b0;
    for (int k = 0; k < REQ_STAGE; k++) begin
      ld_words[k] = '{kind: KIND_REQUEST, data: 8'd0, last: 1'b0, status: ST_OK};
    end

    n_total     = {2'b00, expected_payload} + 10'(REPLY_OVERHEAD);
    i_plus2     = {1'b0, received_count} + 10'd2;
    i_plus1     = {1'b0, received_count} + 10'd1;
    has_payload = 1'b0;
    final_byte  = 1'b0;
    st          = ST_OK;
    pay_w = '{kind: KIND_PAYLOAD, data: in_rx, last: 1'b0, status: ST_OK};
    st_w  = '{kind: KIND_STATUS, data: 8'd0, last: 1'b0, status: ST_OK};

    if (accept) begin
      unique case (s_tuser)
        MODE_START: begin
          ld_en  = 1'b1;
          ld_cnt = 3'(REQ_LEN);
          ld_req = 1'b1;
          ld_words[0].data = device_address;
          ld_words[1].data = {1'b0, function_code};
          ld_words[2].data = in_addr[15:8];
          ld_words[3].data = in_addr[7:0];
          ld_words[4].data = in_count;
          phase_next            = PH_RECEIVE;
          received_count_next   = 9'd0;
          expected_payload_next = in_count;
          running_crc_next      = CRC_INIT;
          held_bytes_next       = 16'd0;
          second_byte_next      = 8'd0;
          header_bad_next       = 1'b0;
        end
        MODE_TIMEOUT: begin
          if (phase == PH_RECEIVE) begin
            ld_en  = 1'b1;
            ld_cnt = 3'd1;
            st_w.status = ST_SHORT;
            ld_words[0] = st_w;
            phase_next  = PH_IDLE;
          end
        end
        MODE_RX: begin
          if (phase == PH_RECEIVE) begin
            // header checks on the first three reply bytes
            if ((received_count == 9'd0) && (in_rx != device_address)) begin
              header_bad_next = 1'b1;
            end
            if (received_count == 9'd1) begin
              second_byte_next = in_rx;
              if (in_rx != {1'b0, function_code}) begin
                header_bad_next = 1'b1;
              end
            end
            if ((received_count == 9'd2) && (in_rx != expected_payload)) begin
              header_bad_next = 1'b1;
            end
            // body bytes feed the crc, trailing two are held
            if (i_plus2 < n_total) begin
              running_crc_next = crc16_step(running_crc, in_rx);
              has_payload      = (received_count >= 9'd3);
            end else if (i_plus2 == n_total) begin
              held_bytes_next[7:0] = in_rx;
            end else begin
              held_bytes_next[15:8] = in_rx;
            end
            received_count_next = i_plus1[8:0];
            final_byte          = (i_plus1 >= n_total);
            // final status in priority order
            if (second_byte_next == {1'b1, function_code}) begin
              st = ST_EXCEPTION;
            end else if (header_bad_next) begin
              st = ST_HEADER;
            end else if (held_bytes_next != running_crc_next) begin
              st = ST_CRC;
            end else begin
              st = ST_OK;
            end
            st_w.status = st;
            if (final_byte) begin
              phase_next = PH_IDLE;
            end
            if (has_payload && final_byte) begin
              ld_en  = 1'b1;
              ld_cnt = 3'd2;
              ld_words[0] = pay_w;
              ld_words[1] = st_w;
            end else if (has_payload) begin
              ld_en  = 1'b1;
              ld_cnt = 3'd1;
              ld_words[0] = pay_w;
            end else if (final_byte) begin
              ld_en  = 1'b1;
              ld_cnt = 3'd1;
              ld_words[0] = st_w;
            end
          end
        end
        default: begin
          // unused mode code, no result and no state change
        end
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= DEVICE_ADDRESS_RESET;
      function_code    <= FUNCTION_CODE_RESET;
      phase            <= PH_IDLE;
      received_count   <= 9'd0;
      expected_payload <= 8'd0;
      running_crc      <= CRC_INIT;
      held_bytes       <= 16'd0;
      second_byte      <= 8'd0;
      header_bad       <= 1'b0;
      out_cnt          <= 3'd0;
      out_req          <= 1'b0;
      tx_crc           <= CRC_INIT;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DEVICE_ADDRESS: device_address <= cfg_data;
          REG_FUNCTION_CODE:  function_code  <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
      phase            <= phase_next;
      received_count   <= received_count_next;
      expected_payload <= expected_payload_next;
      running_crc      <= running_crc_next;
      held_bytes       <= held_bytes_next;
      second_byte      <= second_byte_next;
      header_bad       <= header_bad_next;
      // queue count and request crc
      if (ld_en) begin
        out_cnt <= ld_cnt;
        out_req <= ld_req;
        tx_crc  <= CRC_INIT;
      end else if (pop) begin
        out_cnt <= out_cnt - 3'd1;
        if (out_req && (out_cnt > 3'd2)) begin
          tx_crc <= crc16_step(tx_crc, words[0].data);
        end
      end
    end
  end

  // queue words, shifted toward the head as they are taken
  always_ff @(posedge clk) begin
    if (ld_en) begin
      for (int k = 0; k < REQ_STAGE; k++) begin
        words[k] <= ld_words[k];
      end
    end else if (pop) begin
      for (int k = 0; k < REQ_STAGE - 1; k++) begin
        words[k] <= words[k + 1];
      end
    end
  end

endmodule

### tb/framer_checker.sv
// result checker for the modbus ram read framer: snoops all channels, predicts and compares
`timescale 1ns / 100ps

module framer_checker
  import mrrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // read_addr[15:0], byte_count[23:16], rx_byte[31:24]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // data_byte[7:0], status[10:8], zero[15:11]
  input  logic [1:0]  m_tuser,   // kind[1:0]
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);

  // shadow of the configuration registers
  logic [7:0]  dev_addr;
  logic [6:0]  func_code;

  // shadow of the reply tracking state
  phase_t      rx_phase;
  logic [8:0]  rcv_count;
  logic [7:0]  payload_len;
  logic [15:0] reply_crc;
  logic [15:0] crc_field;
  logic [7:0]  reply_func;
  logic        hdr_bad;

  // result words still owed by the block, oldest first
  out_word_t   owed_words [$];

  // one byte of crc-16/modbus, lsb first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  task automatic owe_word(input kind_t k, input logic [7:0] d, input logic l,
                          input status_t st);
    out_word_t w;
    w.kind   = k;
    w.data   = d;
    w.last   = l;
    w.status = st;
    owed_words.push_back(w);
  endtask

  // work out the result words of one accepted command word
  task automatic predict_cmd(input logic [1:0] mode, input logic [15:0] addr,
                             input logic [7:0] cnt, input logic [7:0] rx);
    logic [7:0]  req [5];
    logic [15:0] crc;
    logic [8:0]  frame_len;
    logic [8:0]  idx;
    status_t     st;
    if (mode == MODE_START) begin
      // request run: header, address, count, crc low then high
      req[0] = dev_addr;
      req[1] = {1'b0, func_code};
      req[2] = addr[15:8];
      req[3] = addr[7:0];
      req[4] = cnt;
      crc = CRC_INIT;
      for (int i = 0; i < 5; i++) begin
        crc = crc_fold(crc, req[i]);
        owe_word(KIND_REQUEST, req[i], 1'b0, ST_OK);
      end
      owe_word(KIND_REQUEST, crc[7:0], 1'b0, ST_OK);
      owe_word(KIND_REQUEST, crc[15:8], 1'b1, ST_OK);
      rx_phase    = PH_RECEIVE;
      rcv_count   = '0;
      payload_len = cnt;
      reply_crc   = CRC_INIT;
      crc_field   = '0;
      reply_func  = '0;
      hdr_bad     = 1'b0;
    end else if (rx_phase == PH_IDLE || mode == MODE_RESERVED) begin
      // ignored
    end else if (mode == MODE_TIMEOUT) begin
      owe_word(KIND_STATUS, 8'h00, 1'b0, ST_SHORT);
      rx_phase = PH_IDLE;
    end else begin
      frame_len = {1'b0, payload_len} + 9'(REPLY_OVERHEAD);
      idx       = rcv_count;
      // header checks on the first three reply bytes
      if (idx == 0 && rx != dev_addr) hdr_bad = 1'b1;
      if (idx == 1) begin
        reply_func = rx;
        if (rx != {1'b0, func_code}) hdr_bad = 1'b1;
      end
      if (idx == 2 && rx != payload_len) hdr_bad = 1'b1;
      // body bytes feed the crc, the last two are the crc itself
      if (idx + 2 < frame_len) begin
        reply_crc = crc_fold(reply_crc, rx);
        if (idx >= 3) owe_word(KIND_PAYLOAD, rx, 1'b0, ST_OK);
      end else if (idx + 2 == frame_len) begin
        crc_field[7:0] = rx;
      end else begin
        crc_field[15:8] = rx;
      end
      rcv_count = idx + 9'd1;
      // frame complete: exception, header, crc, ok in that order
      if (idx + 1 >= frame_len) begin
        if (reply_func == {1'b1, func_code}) st = ST_EXCEPTION;
        else if (hdr_bad) st = ST_HEADER;
        else if (crc_field != reply_crc) st = ST_CRC;
        else st = ST_OK;
        owe_word(KIND_STATUS, 8'h00, 1'b0, st);
        rx_phase = PH_IDLE;
      end
    end
  endtask

  // compare one accepted result word with the oldest owed word
  task automatic check_result();
    out_word_t want;
    if (owed_words.size() == 0) begin
      $error("result word with nothing owed: kind %0d data %0h status %0d",
             m_tuser, m_tdata[7:0], m_tdata[10:8]);
      errors++;
    end else begin
      want = owed_words.pop_front();
      if (m_tuser !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, m_tuser);
        errors++;
      end
      if (m_tdata[7:0] !== want.data) begin
        $error("data_byte: expected %0h, got %0h", want.data, m_tdata[7:0]);
        errors++;
      end
      if (m_tlast !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, m_tlast);
        errors++;
      end
      if (m_tdata[10:8] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, m_tdata[10:8]);
        errors++;
      end
      if (m_tdata[15:11] !== 5'd0) begin
        $error("pad: expected 0, got %0h", m_tdata[15:11]);
        errors++;
      end
    end
  endtask

  // snoop the three channels, sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      errors      = 0;
      dev_addr    = DEVICE_ADDRESS_RESET;
      func_code   = FUNCTION_CODE_RESET;
      rx_phase    = PH_IDLE;
      rcv_count   = '0;
      payload_len = '0;
      reply_crc   = CRC_INIT;
      crc_field   = '0;
      reply_func  = '0;
      hdr_bad     = 1'b0;
      owed_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DEVICE_ADDRESS) dev_addr = cfg_data;
        else if (cfg_index == REG_FUNCTION_CODE) func_code = cfg_data[6:0];
      end
      if (s_tvalid && s_tready) begin
        predict_cmd(s_tuser, s_tdata[15:0], s_tdata[23:16], s_tdata[31:24]);
      end
      if (m_tvalid && m_tready) begin
        check_result();
      end
    end
    pending = owed_words.size();
  end

endmodule

### tb/tb_top.sv
// top of the framer testbench: clock, reset, stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module tb_top;
  import mrrf_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam logic [1:0]  REG_SPARE     = 2'd2;

  // shapes of reply that an exchange can take
  typedef enum int {
    REPLY_GOOD,
    REPLY_EXCEPTION,
    REPLY_BAD_HEADER,
    REPLY_BAD_CRC,
    REPLY_CUT_TIMEOUT,
    REPLY_CUT_RESTART
  } reply_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [31:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = '0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;
  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_ready;

  int          errors;
  int          pending;
  int          cycles        = 0;
  int          items_sent    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_req      = 1'b0;

  // register values as last written, used to build replies
  logic [7:0]  cur_dev  = DEVICE_ADDRESS_RESET;
  logic [6:0]  cur_func = FUNCTION_CODE_RESET;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  modbus_ram_read_framer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  framer_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one command word with random gaps ahead of it, wait for accept
  task automatic send_word(input logic [1:0] mode, input logic [15:0] addr,
                           input logic [7:0] cnt, input logic [7:0] rx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {rx, cnt, addr};
    do @(posedge clk); while (!s_tready);
    if (mode != MODE_RESERVED) items_sent++;
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_DEVICE_ADDRESS) cur_dev = val;
    else if (idx == REG_FUNCTION_CODE) cur_func = val[6:0];
  endtask

  // pause the sender until every owed word is out, then let the block settle
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // start a read, then feed back a reply of the given shape
  task automatic run_exchange(input logic [15:0] addr, input logic [7:0] cnt,
                              input reply_t how, input int cut);
    logic [7:0]  frame [$];
    logic [15:0] crc;
    int          spot;
    int          len;
    send_word(MODE_START, addr, cnt, 8'($urandom));
    frame.push_back(cur_dev);
    frame.push_back({how == REPLY_EXCEPTION, cur_func});
    frame.push_back(cnt);
    for (int i = 0; i < cnt; i++) frame.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (frame[i]) crc = crc16_step(crc, frame[i]);
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    // damage the reply where asked
    if (how == REPLY_BAD_HEADER) begin
      spot = $urandom_range(2);
      frame[spot] = frame[spot] ^ (8'h01 << $urandom_range(7));
    end else if (how == REPLY_BAD_CRC) begin
      spot = $urandom_range(frame.size() - 1, 3);
      frame[spot] = frame[spot] ^ (8'h01 << $urandom_range(7));
    end
    len = frame.size();
    if (how == REPLY_CUT_TIMEOUT || how == REPLY_CUT_RESTART) begin
      len = (cut < frame.size()) ? cut : frame.size() - 1;
    end
    // reply bytes, with the odd reserved-mode word mixed in
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(24) == 0) begin
        send_word(MODE_RESERVED, 16'($urandom), 8'($urandom), 8'($urandom));
      end
      send_word(MODE_RX, 16'($urandom), 8'($urandom), frame[i]);
    end
    if (how == REPLY_CUT_TIMEOUT) begin
      send_word(MODE_TIMEOUT, 16'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // mostly well-formed exchanges, some damaged ones and some loose noise
  task automatic run_random(input int count);
    int target;
    int pick;
    int cnt;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      cnt  = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(4);
      if (pick < 45) run_exchange(16'($urandom), 8'(cnt), REPLY_GOOD, 0);
      else if (pick < 55) run_exchange(16'($urandom), 8'(cnt), REPLY_EXCEPTION, 0);
      else if (pick < 67) run_exchange(16'($urandom), 8'(cnt), REPLY_BAD_HEADER, 0);
      else if (pick < 79) run_exchange(16'($urandom), 8'(cnt), REPLY_BAD_CRC, 0);
      else if (pick < 87) run_exchange(16'($urandom), 8'($urandom_range(255)),
                                       REPLY_CUT_TIMEOUT, $urandom_range(8));
      else if (pick < 93) run_exchange(16'($urandom), 8'($urandom_range(255)),
                                       REPLY_CUT_RESTART, $urandom_range(8));
      else begin
        repeat ($urandom_range(3, 1)) begin
          send_word(2'($urandom_range(3)), 16'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end
    send_word(MODE_TIMEOUT, 16'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // main sequence
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset register values, idle-state noise, extremes, restart and cut reply
    send_idle_pct = 17;
    recv_idle_pct = 49;
    send_word(MODE_RX, 16'hFFFF, 8'hFF, 8'hFF);
    send_word(MODE_TIMEOUT, 16'h0000, 8'h00, 8'h00);
    send_word(MODE_RESERVED, 16'hFFFF, 8'hFF, 8'hFF);
    run_exchange(16'hFFFF, 8'd0, REPLY_GOOD, 0);
    send_word(MODE_START, 16'h0000, 8'hFF, 8'h00);
    send_word(MODE_RESERVED, 16'h0000, 8'h00, 8'h00);
    run_exchange(16'h1234, 8'd1, REPLY_EXCEPTION, 0);
    run_exchange(16'h00FF, 8'd2, REPLY_CUT_TIMEOUT, 3);
    wait_drain();

    // low extremes of both registers, plus a write to an unused index
    cfg_write(REG_DEVICE_ADDRESS, 8'h00);
    cfg_write(REG_FUNCTION_CODE, 8'h00);
    cfg_write(REG_SPARE, 8'hA5);

    // long receiver hold-off while starts keep coming, then a full drain
    hold_req = 1'b1;
    repeat (4) send_word(MODE_START, 16'($urandom), 8'($urandom), 8'($urandom));
    send_word(MODE_TIMEOUT, 16'($urandom), 8'($urandom), 8'($urandom));
    wait_drain();
    run_random(40);
    wait_drain();

    // high extremes, function write with the top bit set
    send_idle_pct = 49;
    recv_idle_pct = 17;
    cfg_write(REG_DEVICE_ADDRESS, 8'hFF);
    cfg_write(REG_FUNCTION_CODE, 8'hFF);
    run_random(40);
    wait_drain();

    // random registers, no idling, ending with one long reply
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cfg_write(REG_DEVICE_ADDRESS, 8'($urandom));
    cfg_write(REG_FUNCTION_CODE, 8'($urandom));
    run_random(30);
    run_exchange(16'($urandom), 8'd40, REPLY_GOOD, 0);
    send_word(MODE_TIMEOUT, 16'($urandom), 8'($urandom), 8'($urandom));
    wait_drain();

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
